// File: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types, codes and helpers of the pointer click detector.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // event codes
  localparam logic [2:0] OP_ENTER = 3'd0;
  localparam logic [2:0] OP_LEAVE = 3'd1;
  localparam logic [2:0] OP_DOWN  = 3'd2;
  localparam logic [2:0] OP_UP    = 3'd3;
  localparam logic [2:0] OP_EN    = 3'd4;
  localparam logic [2:0] OP_MASK  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_WINDOW   = 2'd2;

  // mode codes as seen on the result port
  localparam logic [1:0] CODE_NONE     = 2'd0;
  localparam logic [1:0] CODE_HOVER    = 2'd1;
  localparam logic [1:0] CODE_PRESS    = 2'd2;
  localparam logic [1:0] CODE_PRESS_IA = 2'd3;

  localparam logic [7:0] DOUBLE_COUNT = 8'd2;
  localparam logic [7:0] COUNT_MAX    = 8'd255;
  localparam logic [2:0] MASK_RESET   = 3'b001;

  // click mode state machine
  typedef enum logic [3:0] {
    MODE_NONE     = 4'b0001,
    MODE_HOVER    = 4'b0010,
    MODE_PRESS    = 4'b0100,
    MODE_PRESS_IA = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [2:0]         button;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        time_ms;
    logic               capture_ok;
    logic               pointer_over;
    logic               enable_value;
  } item_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               mode_written;
    logic               click;
    logic               double_click;
    logic [7:0]         burst_count;
    logic signed [15:0] down_x;
    logic signed [15:0] down_y;
    logic               capture_request;
    logic               release_capture;
  } result_t;

  // press tracking state
  typedef struct packed {
    mode_t              mode;
    logic               enabled;
    logic [2:0]         trigger_mask;
    logic [2:0]         held_button;
    logic signed [15:0] press_x;
    logic signed [15:0] press_y;
  } state_t;

  // multi-click history
  typedef struct packed {
    logic [7:0]         count;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic [2:0]         prev_button;
    logic [31:0]        prev_time;
  } hist_t;

  typedef struct packed {
    logic [14:0] offset_limit_x;
    logic [14:0] offset_limit_y;
    logic [15:0] window_ms;
  } cfg_t;

  // one-hot mode to port code
  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_NONE:     c = CODE_NONE;
      MODE_HOVER:    c = CODE_HOVER;
      MODE_PRESS:    c = CODE_PRESS;
      MODE_PRESS_IA: c = CODE_PRESS_IA;
      default:       c = CODE_NONE;
    endcase
    return c;
  endfunction

  // absolute pixel distance, 17 bits covers the full span
  function automatic logic [16:0] abs_diff(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [16:0] d;
    d = {a[15], a} - {b[15], b};
    return d[16] ? 17'(-d) : 17'(d);
  endfunction

endpackage

// File: rtl/pointer_click_detector.sv
// ----------------------------------------------------------------------------
// pointer_click_detector
// Pointer click detection with multi-click counting.
// ----------------------------------------------------------------------------
// Each pointer event gives exactly one result. An accepted event sits in an
// input register, is evaluated against the click state combinationally and
// its result lands in an output register once that is free, which raises
// out_valid. The block takes one event per cycle as long as the result side
// keeps up; with out_ready low it still takes one more event into the input
// register, and only then holds in_ready low until the waiting result is
// taken. Configuration writes are applied at once, and a write that changes
// a value clears the multi-click history.
module pointer_click_detector (
  input  logic               clk,
  input  logic               rst_n,
  // input events
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [2:0]         in_button,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [31:0]        in_time_ms,
  input  logic               in_capture_ok,
  input  logic               in_pointer_over,
  input  logic               in_enable_value,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_mode,
  output logic               out_mode_written,
  output logic               out_click,
  output logic               out_double_click,
  output logic [7:0]         out_burst_count,
  output logic signed [15:0] out_down_x,
  output logic signed [15:0] out_down_y,
  output logic               out_capture_request,
  output logic               out_release_capture,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  pcd_pkg::item_t   in_r;
  logic             in_valid_r;
  pcd_pkg::result_t out_r;
  logic             out_valid_r;
  pcd_pkg::state_t  st_r, st_nxt;
  pcd_pkg::hist_t   hist_r, hist_nxt;
  pcd_pkg::result_t res;
  pcd_pkg::cfg_t    cfg;
  logic             hist_clr;
  logic             advance;

  // configuration registers
  pcd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .hist_clr  (hist_clr)
  );

  // event evaluation
  pcd_step u_step (
    .item     (in_r),
    .st       (st_r),
    .hist     (hist_r),
    .cfg      (cfg),
    .st_nxt   (st_nxt),
    .hist_nxt (hist_nxt),
    .res      (res)
  );

  // handshake: move an event on whenever the output register frees up
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= '{op: in_op, button: in_button, pos_x: in_pos_x, pos_y: in_pos_y,
                time_ms: in_time_ms, capture_ok: in_capture_ok,
                pointer_over: in_pointer_over, enable_value: in_enable_value};
    end
  end

  // click state and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: pcd_pkg::MODE_NONE, enabled: 1'b1,
                trigger_mask: pcd_pkg::MASK_RESET, held_button: 3'd0,
                press_x: 16'sd0, press_y: 16'sd0};
      hist_r <= '0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (hist_clr) begin
        hist_r <= '0;
      end else if (advance) begin
        hist_r <= hist_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mode            = out_r.mode;
  assign out_mode_written    = out_r.mode_written;
  assign out_click           = out_r.click;
  assign out_double_click    = out_r.double_click;
  assign out_burst_count     = out_r.burst_count;
  assign out_down_x          = out_r.down_x;
  assign out_down_y          = out_r.down_y;
  assign out_capture_request = out_r.capture_request;
  assign out_release_capture = out_r.release_capture;

endmodule

// File: rtl/pcd_cfg.sv
// ----------------------------------------------------------------------------
// pcd_cfg
// Configuration registers; flags a history clear when a value changes.
// ----------------------------------------------------------------------------
module pcd_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  output pcd_pkg::cfg_t  cfg,
  output logic           hist_clr
);

  pcd_pkg::cfg_t cfg_r, cfg_nxt;

  // register decode and change detect
  always_comb begin
    cfg_nxt  = cfg_r;
    hist_clr = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        pcd_pkg::REG_OFFSET_X: begin
          cfg_nxt.offset_limit_x = cfg_wdata[14:0];
          hist_clr = (cfg_wdata[14:0] != cfg_r.offset_limit_x);
        end
        pcd_pkg::REG_OFFSET_Y: begin
          cfg_nxt.offset_limit_y = cfg_wdata[14:0];
          hist_clr = (cfg_wdata[14:0] != cfg_r.offset_limit_y);
        end
        pcd_pkg::REG_WINDOW: begin
          cfg_nxt.window_ms = cfg_wdata;
          hist_clr = (cfg_wdata != cfg_r.window_ms);
        end
        default: begin
          cfg_nxt  = cfg_r;
          hist_clr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/pcd_step.sv
// ----------------------------------------------------------------------------
// pcd_step
// Next state, next history and result for one pointer event.
// ----------------------------------------------------------------------------
module pcd_step (
  input  pcd_pkg::item_t   item,
  input  pcd_pkg::state_t  st,
  input  pcd_pkg::hist_t   hist,
  input  pcd_pkg::cfg_t    cfg,
  output pcd_pkg::state_t  st_nxt,
  output pcd_pkg::hist_t   hist_nxt,
  output pcd_pkg::result_t res
);

  logic        btn_trig;
  logic        held_trig;
  logic        held_new_trig;
  logic        same_group;
  logic [7:0]  count_upd;
  logic [31:0] dt;
  logic        clear;

  // multi-click qualification against the history
  assign btn_trig      = |(item.button & st.trigger_mask);
  assign held_trig     = |(st.held_button & st.trigger_mask);
  assign held_new_trig = |(st.held_button & item.button);
  assign dt            = item.time_ms - hist.prev_time;
  assign same_group    = (hist.count != 8'd0) &&
                         (item.button == hist.prev_button) &&
                         (dt <= {16'd0, cfg.window_ms}) &&
                         (pcd_pkg::abs_diff(item.pos_x, hist.prev_x) <=
                          {2'b00, cfg.offset_limit_x}) &&
                         (pcd_pkg::abs_diff(item.pos_y, hist.prev_y) <=
                          {2'b00, cfg.offset_limit_y});
  assign count_upd     = !same_group ? 8'd1 :
                         (hist.count == pcd_pkg::COUNT_MAX) ? hist.count : hist.count + 8'd1;

  // event decode
  always_comb begin
    st_nxt = st;
    hist_nxt = hist;
    clear = 1'b0;
    res = '0;
    unique case (item.op)
      pcd_pkg::OP_ENTER: begin
        if (st.enabled) begin
          if (st.mode == pcd_pkg::MODE_PRESS_IA) begin
            if (held_trig) begin
              st_nxt.mode = pcd_pkg::MODE_PRESS;
              res.mode_written = 1'b1;
            end
          end else begin
            st_nxt.mode = pcd_pkg::MODE_HOVER;
            res.mode_written = 1'b1;
          end
        end
      end
      pcd_pkg::OP_LEAVE: begin
        if (st.enabled) begin
          if (st.mode == pcd_pkg::MODE_PRESS) begin
            if (held_trig) begin
              st_nxt.mode = pcd_pkg::MODE_PRESS_IA;
              res.mode_written = 1'b1;
            end
          end else begin
            st_nxt.mode = pcd_pkg::MODE_NONE;
            res.mode_written = 1'b1;
          end
        end
      end
      pcd_pkg::OP_DOWN: begin
        if (st.enabled && btn_trig && st.mode == pcd_pkg::MODE_HOVER) begin
          res.capture_request = 1'b1;
          if (item.capture_ok) begin
            st_nxt.press_x = item.pos_x;
            st_nxt.press_y = item.pos_y;
            st_nxt.held_button = item.button;
            st_nxt.mode = pcd_pkg::MODE_PRESS;
            res.mode_written = 1'b1;
          end
        end
      end
      pcd_pkg::OP_UP: begin
        if (st.enabled && btn_trig && item.button == st.held_button) begin
          if (st.mode == pcd_pkg::MODE_PRESS) begin
            hist_nxt.count = count_upd;
            hist_nxt.prev_x = item.pos_x;
            hist_nxt.prev_y = item.pos_y;
            hist_nxt.prev_button = item.button;
            hist_nxt.prev_time = item.time_ms;
            st_nxt.mode = pcd_pkg::MODE_HOVER;
            res.mode_written = 1'b1;
            res.click = 1'b1;
            res.double_click = (count_upd == pcd_pkg::DOUBLE_COUNT);
            res.burst_count = count_upd;
            res.down_x = st.press_x;
            res.down_y = st.press_y;
            res.release_capture = 1'b1;
          end else if (st.mode == pcd_pkg::MODE_PRESS_IA) begin
            clear = 1'b1;
            st_nxt.mode = pcd_pkg::MODE_NONE;
            res.mode_written = 1'b1;
            res.release_capture = 1'b1;
          end
        end
      end
      pcd_pkg::OP_EN: begin
        if (item.enable_value != st.enabled) begin
          st_nxt.enabled = item.enable_value;
          if (item.enable_value) begin
            st_nxt.mode = item.pointer_over ? pcd_pkg::MODE_HOVER : pcd_pkg::MODE_NONE;
            res.mode_written = 1'b1;
          end else begin
            clear = 1'b1;
            if (st.mode == pcd_pkg::MODE_PRESS || st.mode == pcd_pkg::MODE_PRESS_IA) begin
              st_nxt.mode = pcd_pkg::MODE_NONE;
              res.mode_written = 1'b1;
              res.release_capture = 1'b1;
            end else if (st.mode == pcd_pkg::MODE_HOVER) begin
              st_nxt.mode = pcd_pkg::MODE_NONE;
              res.mode_written = 1'b1;
            end
          end
        end
      end
      pcd_pkg::OP_MASK: begin
        if (item.button != st.trigger_mask) begin
          st_nxt.trigger_mask = item.button;
          clear = 1'b1;
          if ((st.mode == pcd_pkg::MODE_PRESS || st.mode == pcd_pkg::MODE_PRESS_IA) &&
              !held_new_trig) begin
            st_nxt.mode = item.pointer_over ? pcd_pkg::MODE_HOVER : pcd_pkg::MODE_NONE;
            res.mode_written = 1'b1;
            res.release_capture = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
    if (clear) begin
      hist_nxt = '0;
    end
    res.mode = pcd_pkg::mode_code(st_nxt.mode);
  end

endmodule

// File: rtl/pcd_checker.sv
// ----------------------------------------------------------------------------
// pcd_checker
// Port-level checks of the pointer click detector, bound to the top level.
// ----------------------------------------------------------------------------
module pcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_mode,
  input logic               out_mode_written,
  input logic               out_click,
  input logic               out_double_click,
  input logic [7:0]         out_burst_count,
  input logic signed [15:0] out_down_x,
  input logic signed [15:0] out_down_y,
  input logic               out_release_capture
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_burst_count) && $stable(out_mode))
    else $error("stalled result changed");

  // a click leaves the element hovered and releases capture
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_click |-> out_mode == pcd_pkg::CODE_HOVER && out_mode_written &&
      out_release_capture && out_burst_count != 8'd0)
    else $error("click result inconsistent");

  // double click means exactly two
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_double_click |-> out_click && out_burst_count == pcd_pkg::DOUBLE_COUNT)
    else $error("double click without count two");

  // no click, no click payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_click |-> out_burst_count == 8'd0 && out_down_x == 16'sd0 &&
      out_down_y == 16'sd0)
    else $error("click payload without click");

  // a free output side never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind pointer_click_detector pcd_checker u_pcd_checker (.*);
